// File: hdl/route_table_cost_evaluator_unit_assert.svh
// assertion macros for the route table cost evaluator
// used by the top level only, no other dependencies
`ifndef ROUTE_TABLE_COST_EVALUATOR_UNIT_ASSERT_SVH
`define ROUTE_TABLE_COST_EVALUATOR_UNIT_ASSERT_SVH
// implication checked on every edge outside reset
`define RTCE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RTCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/rtce_pkg.sv
// shared types and constants for the route table cost evaluator
// no dependencies
package rtce_pkg;
    localparam int MaxNodes  = 256;
    localparam int MaxRoutes = 16;
    localparam int NodeW  = $clog2(MaxNodes);
    localparam int RouteW = $clog2(MaxRoutes);
    localparam int LenW   = NodeW + 1;
    localparam int SlotAw = RouteW + NodeW;
    localparam int CostAw = 2 * NodeW;

    localparam logic [2:0] OP_LOAD_COST   = 3'd0;
    localparam logic [2:0] OP_LOAD_DEMAND = 3'd1;
    localparam logic [2:0] OP_INSERT      = 3'd2;
    localparam logic [2:0] OP_DELETE      = 3'd3;
    localparam logic [2:0] OP_EVALUATE    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CFG_ROUTE_COUNT = 2'd0;
    localparam logic [1:0] CFG_CAPACITY    = 2'd1;
    localparam logic [1:0] CFG_PENALTY     = 2'd2;

    localparam logic [47:0] COST_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  from_node;
        logic [7:0]  to_node;
        logic [31:0] cost_value;
        logic [15:0] demand_value;
        logic [3:0]  route_index;
        logic [7:0]  slot_position;
        logic [7:0]  customer_node;
    } in_item_t;

    typedef struct packed {
        logic [47:0] total_cost;
        logic [1:0]  status;
    } out_item_t;

    // accumulator commands from the sequencer
    typedef struct packed {
        logic clear;
        logic add_cost;
        logic add_demand;
        logic route_start;
        logic route_end;
    } acc_ctl_t;
endpackage

// File: hdl/rtce_accum.sv
// adder unit: running cost total, whose adder costs and penalties share, and per-route demand load
// depends on rtce_pkg
module rtce_accum import rtce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  acc_ctl_t    ctl,
    input  logic [31:0] cost_in,
    input  logic [15:0] demand_in,
    input  logic [23:0] capacity,
    input  logic [31:0] penalty,
    output logic [47:0] total
);
    logic [49:0] total_reg, total_next;
    logic [24:0] load_reg, load_next;
    logic        over_reg, over_next;
    logic [49:0] addend;

    always_comb
    begin
        addend = '0;
        if (ctl.add_cost)
            addend = {18'd0, cost_in};
        else if (ctl.route_end && over_reg)
            addend = {18'd0, penalty};
        total_next = total_reg + addend;
        if (total_next[49:48] != 2'b00)
            total_next = {2'b00, COST_MAX};
        if (ctl.clear)
            total_next = '0;
        load_next = load_reg;
        over_next = over_reg;
        if (ctl.route_start)
        begin
            load_next = '0;
            over_next = 1'b0;
        end
        else if (ctl.add_demand)
        begin
            load_next = load_reg + {9'd0, demand_in};
            if (load_next > {1'b0, capacity})
            begin
                over_next = 1'b1;
                load_next = {1'b0, capacity} + 25'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            load_reg  <= '0;
            over_reg  <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            load_reg  <= load_next;
            over_reg  <= over_next;
        end
    end

    assign total = total_reg[47:0];
endmodule

// File: hdl/route_table_cost_evaluator_unit.sv
// route table cost evaluator: one item at a time, one result per item
// steps per item: loads write their table in decode; insert/delete shift the route one slot at a time,
// a read then a write per slot; evaluate walks each used route slot by slot and skips empty routes
// result shows at the edge the block turns ready; a held result stalls the block
// reset: asynchronous active low; route lengths clear at once, tables undefined
// depends on rtce_pkg, rtce_accum and the assertion header
`include "route_table_cost_evaluator_unit_assert.svh"
module route_table_cost_evaluator_unit import rtce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_SHRD   = 11'b00000000100,
        S_SHWR   = 11'b00000001000,
        S_RSTART = 11'b00000010000,
        S_SRD    = 11'b00000100000,
        S_SLAT   = 11'b00001000000,
        S_LOOK   = 11'b00010000000,
        S_ADD    = 11'b00100000000,
        S_REND   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [4:0]  route_count_reg;
    logic [23:0] capacity_reg;
    logic [31:0] penalty_reg;
    logic [LenW-1:0] len_reg [MaxRoutes];
    logic out_valid_reg;
    out_item_t out_reg;

    logic [NodeW-1:0] slot_mem [2**SlotAw];
    logic [31:0] cost_mem [2**CostAw];
    logic [15:0] demand_mem [MaxNodes];
    logic [NodeW-1:0] slot_rd_reg;
    logic [31:0] cost_rd_reg;
    logic [15:0] demand_rd_reg;

    logic [LenW-1:0] ptr_reg, ptr_next;
    logic [RouteW:0] route_reg, route_next;
    logic [NodeW-1:0] prev_reg, prev_next;
    logic [NodeW-1:0] hold_reg, hold_next;
    logic last_reg, last_next;
    logic [1:0] status_reg, status_next;

    logic slot_we;
    logic slot_re;
    logic [SlotAw-1:0] slot_wa, slot_ra;
    logic [NodeW-1:0] slot_wd;
    logic cost_ra_en;
    logic [CostAw-1:0] cost_ra;
    logic [NodeW-1:0] demand_ra;
    acc_ctl_t acc_ctl;
    logic [47:0] total;
    logic [RouteW:0] routes_used;
    logic [LenW-1:0] cur_len, sel_len;
    logic [RouteW-1:0] ri;

    assign ri = item_reg.route_index[RouteW-1:0];
    assign sel_len = len_reg[ri];
    assign cur_len = len_reg[route_reg[RouteW-1:0]];
    assign routes_used = (route_count_reg > 5'(MaxRoutes)) ? (RouteW+1)'(MaxRoutes)
                                                           : route_count_reg[RouteW:0];

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        route_next  = route_reg;
        prev_next   = prev_reg;
        hold_next   = hold_reg;
        last_next   = last_reg;
        status_next = status_reg;
        slot_we = 1'b0;
        slot_re = 1'b0;
        slot_wa = {ri, ptr_reg[NodeW-1:0]};
        slot_wd = hold_reg;
        slot_ra = {ri, ptr_reg[NodeW-1:0]};
        cost_ra_en = 1'b0;
        cost_ra = '0;
        demand_ra = slot_rd_reg;
        acc_ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                acc_ctl.clear = 1'b1;
                state_next = S_DONE;
                case (item_reg.operation)
                    OP_INSERT:
                    begin
                        if (sel_len >= LenW'(MaxNodes))
                            status_next = ST_FULL;
                        else if ({1'b0, item_reg.slot_position} > sel_len)
                            status_next = ST_RANGE;
                        else
                        begin
                            ptr_next = sel_len;
                            hold_next = item_reg.customer_node;
                            state_next = S_SHRD;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (sel_len == '0)
                            status_next = ST_EMPTY;
                        else if ({1'b0, item_reg.slot_position} >= sel_len)
                            status_next = ST_RANGE;
                        else
                        begin
                            ptr_next = {1'b0, item_reg.slot_position};
                            state_next = S_SHRD;
                        end
                    end
                    OP_EVALUATE:
                    begin
                        route_next = '0;
                        state_next = S_RSTART;
                    end
                    default: ;
                endcase
            end
            S_SHRD:
            begin
                // insert: copy ptr-1 to ptr down to pos; delete: ptr+1 to ptr
                if (item_reg.operation == OP_INSERT)
                begin
                    if (ptr_reg == {1'b0, item_reg.slot_position})
                    begin
                        slot_we = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        slot_re = 1'b1;
                        slot_ra = {ri, ptr_reg[NodeW-1:0] - 1'b1};
                        state_next = S_SHWR;
                    end
                end
                else
                begin
                    if (ptr_reg + 1'b1 >= sel_len)
                        state_next = S_DONE;
                    else
                    begin
                        slot_re = 1'b1;
                        slot_ra = {ri, ptr_reg[NodeW-1:0] + 1'b1};
                        state_next = S_SHWR;
                    end
                end
            end
            S_SHWR:
            begin
                slot_we = 1'b1;
                slot_wd = slot_rd_reg;
                if (item_reg.operation == OP_INSERT)
                    ptr_next = ptr_reg - 1'b1;
                else
                    ptr_next = ptr_reg + 1'b1;
                state_next = S_SHRD;
            end
            S_RSTART:
            begin
                acc_ctl.route_start = 1'b1;
                ptr_next = '0;
                prev_next = '0;
                if (route_reg >= routes_used)
                    state_next = S_DONE;
                else if (cur_len == '0)
                    route_next = route_reg + 1'b1;
                else
                    state_next = S_SRD;
            end
            S_SRD:
            begin
                slot_re = 1'b1;
                slot_ra = {route_reg[RouteW-1:0], ptr_reg[NodeW-1:0]};
                last_next = (ptr_reg == cur_len);
                state_next = S_SLAT;
            end
            S_SLAT:
            begin
                // after the last slot, close the route back at the depot
                cost_ra_en = 1'b1;
                if (last_reg)
                    cost_ra = {prev_reg, {NodeW{1'b0}}};
                else
                    cost_ra = {prev_reg, slot_rd_reg};
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_ctl.add_cost = 1'b1;
                acc_ctl.add_demand = !last_reg;
                prev_next = slot_rd_reg;
                ptr_next = ptr_reg + 1'b1;
                state_next = last_reg ? S_REND : S_SRD;
            end
            S_REND:
            begin
                acc_ctl.route_end = 1'b1;
                route_next = route_reg + 1'b1;
                state_next = S_RSTART;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    rtce_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (acc_ctl),
        .cost_in   (cost_rd_reg),
        .demand_in (demand_rd_reg),
        .capacity  (capacity_reg),
        .penalty   (penalty_reg),
        .total     (total)
    );

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        if (slot_re)
            slot_rd_reg <= slot_mem[slot_ra];
        if (state_reg == S_DECODE && item_reg.operation == OP_LOAD_COST)
            cost_mem[{item_reg.from_node, item_reg.to_node}] <= item_reg.cost_value;
        if (cost_ra_en)
            cost_rd_reg <= cost_mem[cost_ra];
        if (state_reg == S_DECODE && item_reg.operation == OP_LOAD_DEMAND)
            demand_mem[item_reg.from_node] <= item_reg.demand_value;
        demand_rd_reg <= demand_mem[demand_ra];
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            route_reg <= '0;
            prev_reg <= '0;
            hold_reg <= '0;
            last_reg <= 1'b0;
            status_reg <= ST_OK;
            route_count_reg <= 5'd1;
            capacity_reg <= '0;
            penalty_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            for (int i = 0; i < MaxRoutes; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            route_reg <= route_next;
            prev_reg <= prev_next;
            hold_reg <= hold_next;
            last_reg <= last_next;
            status_reg <= status_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROUTE_COUNT: route_count_reg <= cfg_data[4:0];
                    CFG_CAPACITY:    capacity_reg <= cfg_data[23:0];
                    CFG_PENALTY:     penalty_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && state_next == S_IDLE && status_reg == ST_OK)
            begin
                if (item_reg.operation == OP_INSERT)
                    len_reg[ri] <= sel_len + 1'b1;
                else if (item_reg.operation == OP_DELETE)
                    len_reg[ri] <= sel_len - 1'b1;
            end
            if (state_reg == S_DONE && state_next == S_IDLE)
            begin
                out_valid_reg <= 1'b1;
                out_reg.status <= status_reg;
                out_reg.total_cost <= (item_reg.operation == OP_EVALUATE) ? total : '0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `RTCE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg == S_DECODE)
    `RTCE_ASSERT_IMPLY(a_done_status_ok_eval,
        state_reg == S_DONE && item_reg.operation == OP_EVALUATE, status_reg == ST_OK)
    `RTCE_ASSERT_IMPLY(a_len_bounded, state_reg == S_DECODE, sel_len <= LenW'(MaxNodes))
endmodule

// File: tb/testbench.sv
// self-checking testbench for route_table_cost_evaluator_unit
// depends on rtce_pkg and the block; tracks routes, costs and demands to predict each result
module testbench;
    import rtce_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [7:0]  slot_tab [MaxRoutes][MaxNodes];
    int unsigned len_tab [MaxRoutes];
    logic [31:0] cost_tab [MaxNodes*MaxNodes];
    logic [15:0] demand_tab [MaxNodes];
    logic [4:0]  cfg_routes;
    logic [23:0] cfg_capacity;
    logic [31:0] cfg_penalty;

    out_item_t   pending_results [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned evals_sent;
    bit          no_idle;

    route_table_cost_evaluator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [47:0] solution_cost();
        logic [63:0] total;
        logic [63:0] load;
        int unsigned routes;
        int unsigned n;
        total  = 0;
        routes = (cfg_routes > MaxRoutes) ? MaxRoutes : cfg_routes;
        for (int r = 0; r < routes; r++)
        begin
            n    = len_tab[r];
            load = 0;
            if (n == 0)
                continue;
            total += cost_tab[{8'd0, slot_tab[r][0]}];
            for (int j = 0; j + 1 < n; j++)
                total += cost_tab[{slot_tab[r][j], slot_tab[r][j+1]}];
            total += cost_tab[{slot_tab[r][n-1], 8'd0}];
            for (int j = 0; j < n; j++)
                load += demand_tab[slot_tab[r][j]];
            if (load > cfg_capacity)
                total += cfg_penalty;
        end
        return (total > COST_MAX) ? COST_MAX : total[47:0];
    endfunction

    // applies one item to the tracked state and returns its result
    function automatic out_item_t route_outcome(in_item_t it);
        out_item_t   res;
        int unsigned r;
        int unsigned n;
        res = '0;
        r   = it.route_index;
        n   = len_tab[r];
        case (it.operation)
            OP_LOAD_COST:   cost_tab[{it.from_node, it.to_node}] = it.cost_value;
            OP_LOAD_DEMAND: demand_tab[it.from_node] = it.demand_value;
            OP_INSERT:
            begin
                if (n >= MaxNodes)
                    res.status = ST_FULL;
                else if (it.slot_position > n)
                    res.status = ST_RANGE;
                else
                begin
                    for (int l = n; l > it.slot_position; l--)
                        slot_tab[r][l] = slot_tab[r][l-1];
                    slot_tab[r][it.slot_position] = it.customer_node;
                    len_tab[r] = n + 1;
                end
            end
            OP_DELETE:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else if (it.slot_position >= n)
                    res.status = ST_RANGE;
                else
                begin
                    for (int l = it.slot_position; l + 1 < n; l++)
                        slot_tab[r][l] = slot_tab[r][l+1];
                    len_tab[r] = n - 1;
                end
            end
            OP_EVALUATE:    res.total_cost = solution_cost();
            default:        ;
        endcase
        return res;
    endfunction

    // nodes whose costs and demands are always loaded
    function automatic logic [7:0] pool_node(int unsigned k);
        return (k < 4) ? k[7:0] : 8'd255;
    endfunction

    function automatic int unsigned pick_gap();
        if (no_idle || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t typed_result);
        out_item_t   res;
        int unsigned gap;
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = it;
        do
            @(posedge clk);
        while (!in_ready);
        res = route_outcome(it);
        pending_results.push_back(typed ? typed_result : res);
        items_sent++;
        if (it.operation == OP_EVALUATE)
            evals_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            in_data  = $urandom;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send(in_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_ROUTE_COUNT: cfg_routes   = value[4:0];
            CFG_CAPACITY:    cfg_capacity = value[23:0];
            CFG_PENALTY:     cfg_penalty  = value;
            default:         ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic in_item_t make_item(logic [2:0] op, logic [3:0] r, logic [7:0] pos,
                                           logic [7:0] node);
        in_item_t it;
        it               = $urandom;
        it.cost_value    = $urandom;
        it.operation     = op;
        it.route_index   = r;
        it.slot_position = pos;
        it.customer_node = node;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned r;
        int unsigned n;
        pick = $urandom_range(0, 99);
        r    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
        n    = len_tab[r];
        it   = make_item(OP_INSERT, r, 0, pool_node($urandom_range(0, 4)));
        if (pick < 32)
            it.slot_position = ($urandom_range(0, 9) == 0) ? $urandom_range(n + 1, 255)
                                                            : $urandom_range(0, n);
        else if (pick < 52)
        begin
            it.operation     = OP_DELETE;
            it.slot_position = ($urandom_range(0, 9) == 0 || n == 0) ? $urandom_range(n, 255)
                                                                      : $urandom_range(0, n - 1);
        end
        else if (pick < 64)
        begin
            it.operation = OP_LOAD_COST;
            if ($urandom_range(0, 3) != 0)
            begin
                it.from_node = pool_node($urandom_range(0, 4));
                it.to_node   = pool_node($urandom_range(0, 4));
            end
        end
        else if (pick < 72)
        begin
            it.operation = OP_LOAD_DEMAND;
            if ($urandom_range(0, 3) != 0)
                it.from_node = pool_node($urandom_range(0, 4));
        end
        else if (pick < 95)
            it.operation = OP_EVALUATE;
        else
            it.operation = 3'($urandom_range(5, 7));
        return it;
    endfunction

    function automatic void add_row(in_item_t it, bit typed, logic [47:0] cost, logic [1:0] st);
        stim_row_t row;
        row.item              = it;
        row.typed             = typed;
        row.result.total_cost = cost;
        row.result.status     = st;
        directed_rows.push_back(row);
    endfunction

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (no_idle || $urandom_range(0, 9) < 6)
                out_ready = 1'b1;
            else
            begin
                out_ready = 1'b0;
                repeat (($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cost %h status %0d",
                             out_data.total_cost, out_data.status);
            end
            else if (out_data.total_cost !== pending_results[0].total_cost ||
                     out_data.status !== pending_results[0].status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cost %h status %0d, got cost %h status %0d",
                             pending_results[0].total_cost, pending_results[0].status,
                             out_data.total_cost, out_data.status);
                void'(pending_results.pop_front());
            end
            else
                void'(pending_results.pop_front());
        end
    end

    initial
    begin
        in_item_t it;
        int unsigned n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ROUTE_COUNT;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        evals_sent = 0;
        no_idle    = 1'b0;
        cfg_routes   = 5'd1;
        cfg_capacity = '0;
        cfg_penalty  = '0;
        for (int r = 0; r < MaxRoutes; r++)
            len_tab[r] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // right after reset every route is empty
        add_row(make_item(OP_EVALUATE, 0, 0, 1), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_DELETE, 0, 0, 1), 1'b1, 48'd0, ST_EMPTY);
        add_row(make_item(OP_INSERT, 0, 1, 1), 1'b1, 48'd0, ST_RANGE);
        add_row(make_item(OP_INSERT, 15, 255, 1), 1'b1, 48'd0, ST_RANGE);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        directed_rows.delete();

        // load every cost and demand among the node pool
        for (int a = 0; a < 5; a++)
        begin
            it           = make_item(OP_LOAD_DEMAND, 0, 0, 1);
            it.from_node = pool_node(a);
            send(it);
            for (int b = 0; b < 5; b++)
            begin
                it           = make_item(OP_LOAD_COST, 0, 0, 1);
                it.from_node = pool_node(a);
                it.to_node   = pool_node(b);
                if ($urandom_range(0, 3) != 0)
                    it.cost_value = $urandom_range(0, 32'h000F_FFFF);
                send(it);
            end
        end
        drain();
        write_reg(CFG_ROUTE_COUNT, 32'd4);
        write_reg(CFG_CAPACITY, 32'h00FF_FFFF);
        write_reg(CFG_PENALTY, 32'hFFFF_FFFF);

        it            = make_item(OP_LOAD_COST, 0, 0, 1);
        it.from_node  = 8'd255;
        it.to_node    = 8'd255;
        it.cost_value = 32'hFFFF_FFFF;
        add_row(it, 1'b1, 48'd0, ST_OK);
        it              = make_item(OP_LOAD_DEMAND, 0, 0, 1);
        it.from_node    = 8'd255;
        it.demand_value = 16'hFFFF;
        add_row(it, 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_INSERT, 0, 0, 255), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_INSERT, 0, 1, 255), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_INSERT, 0, 0, 0), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_INSERT, 0, 2, 2), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_DELETE, 0, 4, 1), 1'b1, 48'd0, ST_RANGE);
        add_row(make_item(OP_EVALUATE, 0, 0, 1), 1'b0, 48'd0, ST_OK);
        add_row(make_item(3'd5, 0, 0, 1), 1'b1, 48'd0, ST_OK);
        add_row(make_item(3'd6, 0, 0, 1), 1'b1, 48'd0, ST_OK);
        add_row(make_item(3'd7, 0, 0, 1), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_INSERT, 1, 0, 3), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_INSERT, 3, 0, 1), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_EVALUATE, 0, 0, 1), 1'b0, 48'd0, ST_OK);
        add_row(make_item(OP_DELETE, 0, 1, 1), 1'b1, 48'd0, ST_OK);
        add_row(make_item(OP_DELETE, 2, 0, 1), 1'b1, 48'd0, ST_EMPTY);
        add_row(make_item(OP_EVALUATE, 0, 0, 1), 1'b0, 48'd0, ST_OK);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        drain();

        // route count of zero, then above the route limit
        write_reg(CFG_ROUTE_COUNT, 32'd0);
        write_reg(CFG_CAPACITY, 32'd0);
        send(make_item(OP_EVALUATE, 0, 0, 1));
        drain();
        write_reg(CFG_ROUTE_COUNT, 32'd31);
        send(make_item(OP_EVALUATE, 0, 0, 1));
        drain();

        // fill the last route to the brim, overflow it, then shrink it
        no_idle = 1'b1;
        for (int k = 0; k < MaxNodes; k++)
            send(make_item(OP_INSERT, 15, $urandom_range(0, len_tab[15]),
                           pool_node($urandom_range(0, 4))));
        no_idle = 1'b0;
        send(make_item(OP_INSERT, 15, 8'd255, 5));
        send(make_item(OP_INSERT, 15, 8'd0, 5));
        send(make_item(OP_DELETE, 15, 8'd255, 1));
        send(make_item(OP_EVALUATE, 0, 0, 1));
        no_idle = 1'b1;
        while (len_tab[15] > 250)
            send(make_item(OP_DELETE, 15, $urandom_range(0, len_tab[15] - 1), 1));
        no_idle = 1'b0;
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:       write_reg(CFG_ROUTE_COUNT, 32'd16);
                1:       write_reg(CFG_ROUTE_COUNT, 32'd1);
                default: write_reg(CFG_ROUTE_COUNT, $urandom_range(1, 8));
            endcase
            n = $urandom_range(0, 3);
            write_reg(CFG_CAPACITY, (n == 0) ? 32'd0 : (n == 1) ? 32'h00FF_FFFF
                                                                : $urandom_range(0, 200_000));
            write_reg(CFG_PENALTY, (phase == 3) ? 32'd0 : $urandom);
            no_idle = (phase == 4);
            for (int k = 0; k < 15; k++)
                send(random_item());
            drain();
        end

        no_idle = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("%0d items sent, %0d of them evaluations, over reset, full-route and",
                 items_sent, evals_sent);
        $display("varied route count, capacity and penalty settings");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: route_table_cost_evaluator_unit.f
+incdir+hdl
hdl/rtce_pkg.sv
hdl/rtce_accum.sv
hdl/route_table_cost_evaluator_unit.sv
tb/testbench.sv
